[hw/rtl/lrfb_pkg.sv]
// Package for the line raster frame buffer: command/response payload structs,
// command codes, stepper control/status structs and fixed field widths.
// No dependencies.
package lrfb_pkg;

    localparam int COORD_W = 7;
    localparam int X_W     = 7;
    localparam int Y_W     = 6;
    localparam int RADDR_W = 10;
    localparam int DATA_W  = 8;
    localparam int CNT_W   = 8;
    localparam int ERR_W   = COORD_W + 2;

    localparam logic [1:0] FUNC_LINE  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [X_W-1:0]     start_x;
        logic [Y_W-1:0]     start_y;
        logic [X_W-1:0]     end_x;
        logic [Y_W-1:0]     end_y;
        logic               ink;
        logic [RADDR_W-1:0] read_address;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  pixels_drawn;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic advance;
    } t_step_ctrl;

    typedef struct packed {
        logic [COORD_W-1:0] pix_x;
        logic [COORD_W-1:0] pix_y;
        logic               last;
        logic [CNT_W-1:0]   count;
    } t_step_stat;

endpackage

[hw/rtl/lrfb_if.sv]
// Valid/ready channel interfaces for commands and responses.
// Depends on lrfb_pkg.
interface lrfb_cmd_if;
    import lrfb_pkg::*;
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lrfb_rsp_if;
    import lrfb_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/lrfb_line_stepper.sv]
// Bresenham line stepper: endpoint setup on load, one pixel per advance.
// Depends on lrfb_pkg.
module lrfb_line_stepper (
    input  logic                         i_clk,
    input  lrfb_pkg::t_step_ctrl         i_ctrl,
    input  logic [lrfb_pkg::COORD_W-1:0] i_sx,
    input  logic [lrfb_pkg::COORD_W-1:0] i_sy,
    input  logic [lrfb_pkg::COORD_W-1:0] i_ex,
    input  logic [lrfb_pkg::COORD_W-1:0] i_ey,
    output lrfb_pkg::t_step_stat         o_stat
);
    import lrfb_pkg::*;

    logic                     r_steep;
    logic                     r_up;
    logic [COORD_W-1:0]       r_m;
    logic [COORD_W-1:0]       r_minor;
    logic [COORD_W-1:0]       r_dmaj;
    logic [COORD_W-1:0]       r_dmin;
    logic [COORD_W-1:0]       r_left;
    logic signed [ERR_W-1:0]  r_err;

    logic                     n_steep;
    logic                     n_up;
    logic [COORD_W-1:0]       n_m;
    logic [COORD_W-1:0]       n_minor;
    logic [COORD_W-1:0]       n_dmaj;
    logic [COORD_W-1:0]       n_dmin;
    logic [COORD_W-1:0]       n_left;
    logic signed [ERR_W-1:0]  n_err;

    logic [COORD_W-1:0]       dx_abs, dy_abs;
    logic [COORD_W-1:0]       ax, ay, bx, by;
    logic [COORD_W-1:0]       a0x, a0y, b0x, b0y;
    logic                     steep, swap;
    logic signed [ERR_W-1:0]  err_sub;

    always_comb begin
        dx_abs = (i_ex >= i_sx) ? (i_ex - i_sx) : (i_sx - i_ex);
        dy_abs = (i_ey >= i_sy) ? (i_ey - i_sy) : (i_sy - i_ey);
        steep  = dy_abs > dx_abs;
        ax     = steep ? i_sy : i_sx;
        ay     = steep ? i_sx : i_sy;
        bx     = steep ? i_ey : i_ex;
        by     = steep ? i_ex : i_ey;
        swap   = ax > bx;
        a0x    = swap ? bx : ax;
        a0y    = swap ? by : ay;
        b0x    = swap ? ax : bx;
        b0y    = swap ? ay : by;

        err_sub = r_err - $signed({2'b00, r_dmin});

        n_steep = r_steep;
        n_up    = r_up;
        n_m     = r_m;
        n_minor = r_minor;
        n_dmaj  = r_dmaj;
        n_dmin  = r_dmin;
        n_left  = r_left;
        n_err   = r_err;

        if (i_ctrl.load) begin
            n_steep = steep;
            n_up    = a0y < b0y;
            n_m     = a0x;
            n_minor = a0y;
            n_dmaj  = b0x - a0x;
            n_dmin  = (b0y >= a0y) ? (b0y - a0y) : (a0y - b0y);
            n_left  = b0x - a0x;
            n_err   = $signed({2'b00, (b0x - a0x) >> 1});
        end else if (i_ctrl.advance) begin
            n_m    = r_m + COORD_W'(1);
            n_left = r_left - COORD_W'(1);
            if (err_sub < 0) begin
                n_minor = r_up ? (r_minor + COORD_W'(1)) : (r_minor - COORD_W'(1));
                n_err   = err_sub + $signed({2'b00, r_dmaj});
            end else begin
                n_err   = err_sub;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_steep <= n_steep;
        r_up    <= n_up;
        r_m     <= n_m;
        r_minor <= n_minor;
        r_dmaj  <= n_dmaj;
        r_dmin  <= n_dmin;
        r_left  <= n_left;
        r_err   <= n_err;
    end

    assign o_stat.pix_x = r_steep ? r_minor : r_m;
    assign o_stat.pix_y = r_steep ? r_m : r_minor;
    assign o_stat.last  = (r_left == '0);
    assign o_stat.count = CNT_W'(r_dmaj) + CNT_W'(1);

endmodule

[hw/rtl/lrfb_frame_ram.sv]
// Single-write, single-read frame memory with registered read data.
// No dependencies.
module lrfb_frame_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/line_raster_frame_buffer_core.sv]
// Line raster frame buffer top level: command sequencer, pixel address map.
// Line: read-modify-write on the frame RAM for each pixel.
// Read: a single frame RAM read. Clear: one frame byte per cycle.
// One command in flight; the response register frees the input side.
// After reset the frame RAM is swept to zero (command input not ready meanwhile).
// Depends on lrfb_pkg, lrfb_if, lrfb_line_stepper, lrfb_frame_ram.
module line_raster_frame_buffer_core #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrfb_cmd_if.sink   i_cmd,
    lrfb_rsp_if.source o_rsp
);
    import lrfb_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int AW          = $clog2(FRAME_BYTES);
    localparam int COL_W       = $clog2(SCREEN_WIDTH);
    localparam int ROW_W       = $clog2(SCREEN_HEIGHT);
    localparam int COORD_SPAN  = 2 ** COORD_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_PIX   = 6'b000100,
        S_WR    = 6'b001000,
        S_READ  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_idx, n_clr_idx;
    logic               r_clr_cmd, n_clr_cmd;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_rsp, n_rsp;
    logic [1:0]         r_func, n_func;
    logic               r_ink, n_ink;
    logic [AW-1:0]      r_raddr, n_raddr;
    logic               r_rd_ok, n_rd_ok;
    logic [AW-1:0]      r_wr_addr, n_wr_addr;
    logic [7:0]         r_bit, n_bit;

    t_step_ctrl         step_ctrl;
    t_step_stat         step_stat;

    logic [COL_W-1:0]   col_mod [COORD_SPAN];
    logic [ROW_W-1:0]   row_mod [COORD_SPAN];
    logic [COL_W-1:0]   pix_col;
    logic [ROW_W-1:0]   pix_row;
    logic [AW-1:0]      pix_addr;
    logic [7:0]         pix_bit;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [7:0]         ram_wdata, ram_rdata;

    // coordinate wrap tables
    for (genvar gi = 0; gi < COORD_SPAN; gi++) begin : g_mod
        assign col_mod[gi] = COL_W'(gi % SCREEN_WIDTH);
        assign row_mod[gi] = ROW_W'(gi % SCREEN_HEIGHT);
    end

    assign pix_col  = col_mod[step_stat.pix_x];
    assign pix_row  = row_mod[step_stat.pix_y];
    assign pix_addr = AW'(32'(pix_row >> 3) * SCREEN_WIDTH + 32'(pix_col));
    assign pix_bit  = 8'(1) << pix_row[2:0];

    lrfb_line_stepper u_stepper (
        .i_clk  (i_clk),
        .i_ctrl (step_ctrl),
        .i_sx   (COORD_W'(i_cmd.data.start_x)),
        .i_sy   (COORD_W'(i_cmd.data.start_y)),
        .i_ex   (COORD_W'(i_cmd.data.end_x)),
        .i_ey   (COORD_W'(i_cmd.data.end_y)),
        .o_stat (step_stat)
    );

    lrfb_frame_ram #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_clr_cmd   = r_clr_cmd;
        n_out_valid = r_out_valid;
        n_rsp       = r_rsp;
        n_func      = r_func;
        n_ink       = r_ink;
        n_raddr     = r_raddr;
        n_rd_ok     = r_rd_ok;
        n_wr_addr   = r_wr_addr;
        n_bit       = r_bit;
        step_ctrl   = '0;
        ram_we      = 1'b0;
        ram_waddr   = r_wr_addr;
        ram_wdata   = r_ink ? (ram_rdata | r_bit) : (ram_rdata & ~r_bit);
        ram_re      = 1'b0;
        ram_raddr   = pix_addr;
        i_cmd.ready = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
                if (r_clr_idx == AW'(FRAME_BYTES - 1)) begin
                    n_clr_idx = '0;
                    n_state   = r_clr_cmd ? S_DONE : S_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + AW'(1);
                end
            end
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_func  = i_cmd.data.func;
                    n_ink   = i_cmd.data.ink;
                    n_raddr = AW'(i_cmd.data.read_address);
                    n_rd_ok = 32'(i_cmd.data.read_address) < 32'(FRAME_BYTES);
                    case (i_cmd.data.func)
                        FUNC_LINE: begin
                            step_ctrl.load = 1'b1;
                            n_state        = S_PIX;
                        end
                        FUNC_READ: n_state = S_READ;
                        FUNC_CLEAR: begin
                            n_clr_cmd = 1'b1;
                            n_state   = S_CLEAR;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_PIX: begin
                ram_re    = 1'b1;
                ram_raddr = pix_addr;
                n_wr_addr = pix_addr;
                n_bit     = pix_bit;
                n_state   = S_WR;
            end
            S_WR: begin
                ram_we            = 1'b1;
                step_ctrl.advance = !step_stat.last;
                n_state           = step_stat.last ? S_DONE : S_PIX;
            end
            S_READ: begin
                ram_re    = 1'b1;
                ram_raddr = r_raddr;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid        = 1'b1;
                    n_rsp.read_data    = (r_func == FUNC_READ && r_rd_ok) ? ram_rdata : '0;
                    n_rsp.pixels_drawn = (r_func == FUNC_LINE) ? step_stat.count : '0;
                    n_clr_cmd          = 1'b0;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_clr_cmd   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_clr_cmd   <= n_clr_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp     <= n_rsp;
        r_func    <= n_func;
        r_ink     <= n_ink;
        r_raddr   <= n_raddr;
        r_rd_ok   <= n_rd_ok;
        r_wr_addr <= n_wr_addr;
        r_bit     <= n_bit;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

endmodule
